FILE: rtl/vric_pkg.sv
// shared types and constants for the variable-rate integral controller
package vric_pkg;

  // register file layout
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 16;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_KP_GAIN        = 2'd0,
    REG_INTEGRAL_LIMIT = 2'd1,
    REG_SOFTNESS       = 2'd2
  } vric_reg_t;

  // register widths and reset values
  localparam int unsigned KP_WIDTH    = 16;
  localparam int unsigned LIMIT_WIDTH = 15;
  localparam int unsigned SOFT_WIDTH  = 8;

  localparam logic [KP_WIDTH-1:0]    KP_RESET    = 16'd256;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 15'd2560;
  localparam logic [SOFT_WIDTH-1:0]  SOFT_RESET  = 8'd5;

  // integral and quotient widths
  localparam int unsigned INTEG_WIDTH = 16;
  localparam int unsigned QUOT_WIDTH  = 16;
  localparam int unsigned SUM_WIDTH   = INTEG_WIDTH + 2;

  // sequencer step counts: two gain bits per multiply step, one quotient bit per divide step
  localparam int unsigned MUL_STEPS = KP_WIDTH / 2;
  localparam int unsigned DIV_STEPS = QUOT_WIDTH;
  localparam int unsigned CNT_WIDTH = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } vric_state_t;

endpackage

FILE: rtl/variable_rate_integral_controller_unit.sv
// Usage notes:
// Slave stream (s_tvalid/s_tready/s_tdata) takes one word per control update holding the
// setpoint and the measured value. Master stream (m_tvalid/m_tready/m_tdata/m_tuser)
// returns one word per update: saturated proportional drive, error, updated integral,
// and in m_tuser the flag that the drive was clipped.
// The cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes kp_gain, integral_limit
// and softness; it is always ready and must only be used while no update is in flight.
// After a word is taken the sequencer runs the shift-add multiply (two gain bits a
// cycle, the softness product alongside), then the restoring divide for the increment
// (one quotient bit a cycle), then a step forming the sums and a step loading the
// output register. A new word can be taken only once the result has been loaded into
// the output register, so the block works on one update at a time.
// s_tready is high only while the sequencer is idle. A result waiting on a stalled
// receiver holds the sequencer in its output step until m_tready frees the register.
// Reset (rst, synchronous) restores the register defaults, clears the integral, empties
// the output register and leaves the block ready for a new word.
module variable_rate_integral_controller_unit #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // input words
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // bits from lowest: target_value, actual_value, zero fill
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
  // result words
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // bits from lowest: drive, error_now, integral_now, zero fill
  output logic [((2*SAMPLE_WIDTH+1+vric_pkg::INTEG_WIDTH+7)/8)*8-1:0] m_tdata,
  // bits from lowest: drive_saturated
  output logic                                     m_tuser,
  // configuration writes
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [vric_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [vric_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

  import vric_pkg::*;

  localparam int unsigned W        = SAMPLE_WIDTH;
  localparam int unsigned OUT_BITS = 2*W + 1 + INTEG_WIDTH;
  localparam int unsigned OUT_TW   = ((OUT_BITS+7)/8)*8;
  localparam int unsigned KPP_W    = W + KP_WIDTH + 1;
  localparam int unsigned SP_W     = W + SOFT_WIDTH + 1;

  // configuration registers
  logic [KP_WIDTH-1:0]    kp_gain;
  logic [LIMIT_WIDTH-1:0] integral_limit;
  logic [SOFT_WIDTH-1:0]  softness;

  // controller state
  logic signed [INTEG_WIDTH-1:0] error_integral;

  // sequencer
  vric_state_t          state, state_next;
  logic [CNT_WIDTH-1:0] cnt;
  logic                 in_take, out_load, mul_last, div_last;

  // working registers
  logic signed [W:0]        err;
  logic                     neg;
  logic [W:0]               mag;
  logic [KP_WIDTH-1:0]      kp_sh;
  logic [KPP_W-1:0]         mk, acc_kp;
  logic [SOFT_WIDTH-1:0]    s_sh;
  logic [SP_W-1:0]          ms, acc_s;
  logic [W+1:0]             den, rem;
  logic [QUOT_WIDTH-1:0]    num_sh, quo;
  logic signed [W+9:0]      drive_full;
  logic signed [SUM_WIDTH-1:0] integ_sum;

  // output register
  logic [W-1:0]           out_drive;
  logic [W:0]             out_err;
  logic [INTEG_WIDTH-1:0] out_integ;
  logic                   out_sat;

  // combinational datapath
  logic signed [W-1:0]         tgt_in, act_in;
  logic signed [W:0]           err_in;
  logic [W:0]                  mag_in;
  logic [KPP_W-1:0]            kp_pp, acc_kp_sum;
  logic [SP_W-1:0]             s_pp, acc_s_sum;
  logic [W+2:0]                trial;
  logic [W+3:0]                diff;
  logic                        ge;
  logic [W+1:0]                rem_next;
  logic signed [KPP_W:0]       prod;
  logic [QUOT_WIDTH-1:0]       q_eff;
  logic signed [QUOT_WIDTH:0]  inc;
  logic                        fits;
  logic [W-1:0]                drive_sat;
  logic signed [SUM_WIDTH-1:0] lim_s, integ_clamp;

  assign cfg_ready = 1'b1;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain        <= KP_RESET;
      integral_limit <= LIMIT_RESET;
      softness       <= SOFT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KP_GAIN:        kp_gain        <= cfg_data[KP_WIDTH-1:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LIMIT_WIDTH-1:0];
        REG_SOFTNESS:       softness       <= cfg_data[SOFT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_MUL;
      ST_MUL:  if (mul_last) state_next = ST_DIV;
      ST_DIV:  if (div_last) state_next = ST_SUM;
      ST_SUM:  state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    in_take  = (state == ST_IDLE) && s_tvalid;
    out_load = (state == ST_OUT) && (!m_tvalid || m_tready);
    mul_last = (cnt == CNT_WIDTH'(MUL_STEPS-1));
    div_last = (cnt == CNT_WIDTH'(DIV_STEPS-1));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // error, shift-add partial products, divide step, sums and saturation
  always_comb begin
    tgt_in = $signed(s_tdata[W-1:0]);
    act_in = $signed(s_tdata[2*W-1:W]);
    err_in = {tgt_in[W-1], tgt_in} - {act_in[W-1], act_in};
    mag_in = err_in[W] ? (W+1)'(-err_in) : (W+1)'(err_in);

    unique case (kp_sh[1:0])
      2'd0: kp_pp = '0;
      2'd1: kp_pp = mk;
      2'd2: kp_pp = mk << 1;
      2'd3: kp_pp = (mk << 1) + mk;
    endcase
    acc_kp_sum = acc_kp + kp_pp;
    s_pp       = s_sh[0] ? ms : '0;
    acc_s_sum  = acc_s + s_pp;

    trial    = {rem, num_sh[QUOT_WIDTH-1]};
    diff     = {1'b0, trial} - {2'b00, den};
    ge       = !diff[W+3];
    rem_next = ge ? diff[W+1:0] : trial[W+1:0];

    prod  = neg ? -$signed({1'b0, acc_kp}) : $signed({1'b0, acc_kp});
    q_eff = (den == '0) ? '0 : quo;
    inc   = neg ? -$signed({1'b0, q_eff}) : $signed({1'b0, q_eff});

    // drive fits when the bits above its sign agree with it
    fits      = (drive_full[W+9:W-1] == '0) || (drive_full[W+9:W-1] == '1);
    drive_sat = fits ? drive_full[W-1:0]
                     : (drive_full[W+9] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    lim_s = $signed({{(SUM_WIDTH-LIMIT_WIDTH){1'b0}}, integral_limit});
    if (integ_sum > lim_s)       integ_clamp = lim_s;
    else if (integ_sum < -lim_s) integ_clamp = -lim_s;
    else                         integ_clamp = integ_sum;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      err    <= err_in;
      neg    <= err_in[W];
      mag    <= mag_in;
      kp_sh  <= kp_gain;
      s_sh   <= softness;
      mk     <= KPP_W'(mag_in);
      ms     <= SP_W'(mag_in);
      acc_kp <= '0;
      acc_s  <= '0;
      cnt    <= '0;
    end else if (state == ST_MUL) begin
      kp_sh  <= kp_sh >> 2;
      mk     <= mk << 2;
      s_sh   <= s_sh >> 1;
      ms     <= ms << 1;
      acc_kp <= acc_kp_sum;
      acc_s  <= acc_s_sum;
      if (mul_last) begin
        // numerator is 256*s*|e|: its top part seeds the remainder
        den    <= {1'b0, mag} + (W+2)'(softness);
        rem    <= (W+2)'(acc_s_sum[SP_W-1:8]);
        num_sh <= {acc_s_sum[7:0], 8'h00};
        cnt    <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else if (state == ST_DIV) begin
      rem    <= rem_next;
      quo    <= {quo[QUOT_WIDTH-2:0], ge};
      num_sh <= num_sh << 1;
      cnt    <= cnt + 1'b1;
    end else if (state == ST_SUM) begin
      drive_full <= prod[KPP_W:8];
      integ_sum  <= SUM_WIDTH'(error_integral) + SUM_WIDTH'(inc);
    end
  end

  // integral state commits with the result
  always_ff @(posedge clk) begin
    if (rst)           error_integral <= '0;
    else if (out_load) error_integral <= integ_clamp[INTEG_WIDTH-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive <= drive_sat;
      out_err   <= err;
      out_integ <= integ_clamp[INTEG_WIDTH-1:0];
      out_sat   <= !fits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = OUT_TW'({out_integ, out_err, out_drive});
  assign m_tuser = out_sat;

endmodule

FILE: rtl/vric_checker.sv
// port-level checks for the variable-rate integral controller, with its bind
module vric_checker #(
  parameter int unsigned DATA_WIDTH = 56
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [DATA_WIDTH-1:0] m_tdata
);

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk) rst |=> (s_tready && !m_tvalid))
    else $error("block not idle and empty after reset");

  // one word in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word taken while an update is in flight");

  // a result cannot appear straight after a word is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##2 !$rose(m_tvalid))
    else $error("result appeared too soon after input word");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed or dropped");

endmodule

bind variable_rate_integral_controller_unit vric_checker #(
  .DATA_WIDTH($bits(m_tdata))
) u_vric_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// self-checking bench for the variable-rate integral controller unit
module tb;
  import vric_pkg::*;

  localparam int SW          = 16;
  localparam int S_BITS      = ((2*SW+7)/8)*8;
  localparam int M_BITS      = ((2*SW+1+INTEG_WIDTH+7)/8)*8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_PRINTS  = 100;
  // index outside the register map, writes to it must be dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic signed [SW-1:0]          drive;
    logic signed [SW:0]            err;
    logic signed [INTEG_WIDTH-1:0] integ;
    logic                          sat;
  } ctl_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [S_BITS-1:0]          s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [M_BITS-1:0]          m_tdata;
  logic                       m_tuser;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  // predicted controller state and registers
  logic [KP_WIDTH-1:0]           pred_kp;
  logic [LIMIT_WIDTH-1:0]        pred_limit;
  logic [SOFT_WIDTH-1:0]         pred_soft;
  logic signed [INTEG_WIDTH-1:0] pred_integral;

  ctl_result_t pending_results[$];
  int          fail_count  = 0;
  int          words_seen  = 0;
  int          cycle_count = 0;
  bit          idle_on     = 1'b1;
  int          hold_len    = 0;

  variable_rate_integral_controller_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // proportional drive and variable-speed integral for one update
  function automatic ctl_result_t predict_update(logic signed [SW-1:0] tgt,
                                                 logic signed [SW-1:0] act);
    longint e, mag, prod, drv, denom, q, inc, acc, lim;
    ctl_result_t r;
    e    = longint'(tgt) - longint'(act);
    mag  = (e < 0) ? -e : e;
    prod = longint'(pred_kp) * e;
    // arithmetic shift gives floor rounding
    drv   = prod >>> 8;
    r.sat = 1'b0;
    if (drv > 32767) begin
      drv   = 32767;
      r.sat = 1'b1;
    end
    if (drv < -32768) begin
      drv   = -32768;
      r.sat = 1'b1;
    end
    // increment grows with the error but levels off toward 256*softness, truncated toward zero
    denom = mag + longint'(pred_soft);
    inc   = 0;
    if (denom > 0) begin
      q   = (256 * longint'(pred_soft) * mag) / denom;
      inc = (e < 0) ? -q : q;
    end
    lim = longint'(pred_limit);
    acc = longint'(pred_integral) + inc;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    pred_integral = acc[INTEG_WIDTH-1:0];
    r.drive = drv[SW-1:0];
    r.err   = e[SW:0];
    r.integ = acc[INTEG_WIDTH-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    if (fail_count < MAX_PRINTS)
      $display("word %0d: %s is %0d, expected %0d", words_seen, field, got, want);
    fail_count++;
  endtask

  // offer one input word, predicting its result once taken
  task automatic send_sample(input int tgt, input int act);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_BITS'({act[SW-1:0], tgt[SW-1:0]});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_update(tgt[SW-1:0], act[SW-1:0]));
  endtask

  // stop offering and wait for every predicted word to come back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // write all three registers, optionally poking the unmapped index too
  task automatic configure(input logic [15:0] kp, input logic [15:0] lim,
                           input logic [15:0] soft_val, input bit poke_unmapped);
    logic [CFG_INDEX_WIDTH-1:0] idx[4];
    logic [15:0]                val[4];
    int                         n;
    idx[0] = REG_KP_GAIN;
    val[0] = kp;
    idx[1] = REG_INTEGRAL_LIMIT;
    val[1] = lim;
    idx[2] = REG_SOFTNESS;
    val[2] = soft_val;
    idx[3] = REG_UNMAPPED;
    val[3] = 16'hFFFF;
    n = poke_unmapped ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        REG_KP_GAIN:        pred_kp    = val[i];
        REG_INTEGRAL_LIMIT: pred_limit = val[i][LIMIT_WIDTH-1:0];
        REG_SOFTNESS:       pred_soft  = val[i][SOFT_WIDTH-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // full range, near-equal pairs, or edge values
  task automatic send_random;
    int tgt, act, sel, edges[5];
    edges = '{-32768, -1, 0, 1, 32767};
    sel = $urandom_range(0, 9);
    act = $signed($urandom_range(0, 65535)) - 32768;
    if (sel < 4) begin
      tgt = $signed($urandom_range(0, 65535)) - 32768;
    end else if (sel < 9) begin
      tgt = act + $signed($urandom_range(0, 80)) - 40;
      if (tgt > 32767) tgt = 32767;
      if (tgt < -32768) tgt = -32768;
    end else begin
      tgt = edges[$urandom_range(0, 4)];
      act = edges[$urandom_range(0, 4)];
    end
    send_sample(tgt, act);
  endtask

  // result checker
  initial begin
    int          stall;
    ctl_result_t got, want;
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.drive = m_tdata[SW-1:0];
      got.err   = m_tdata[2*SW:SW];
      got.integ = m_tdata[2*SW+INTEG_WIDTH:2*SW+1];
      got.sat   = m_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, drive", longint'(got.drive), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.drive !== want.drive)
          report_mismatch("drive", longint'(got.drive), longint'(want.drive));
        if (got.err !== want.err)
          report_mismatch("error_now", longint'(got.err), longint'(want.err));
        if (got.integ !== want.integ)
          report_mismatch("integral_now", longint'(got.integ), longint'(want.integ));
        if (got.sat !== want.sat)
          report_mismatch("drive_saturated", longint'(got.sat), longint'(want.sat));
      end
      words_seen++;
    end
  end

  // register defaults, field extremes and a settling run
  task automatic test_reset_defaults;
    send_sample(0, 0);
    send_sample(32767, -32768);
    send_sample(-32768, 32767);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(1, 0);
    send_sample(0, 1);
    send_sample(200, 100);
    send_sample(-5, 5);
    send_sample(-200, 100);
    drain();
  endtask

  // gain, limit and softness extremes plus masked and unmapped writes
  task automatic test_register_extremes;
    // upper bits of limit and softness are dropped
    configure(16'hFFFF, 16'hFFFF, 16'hFF01, 1'b1);
    send_sample(129, 0);
    send_sample(-129, 0);
    send_sample(32767, -32768);
    send_sample(-3, 4);
    drain();
    // zero gain, zero limit holds the integral at zero
    configure(16'h0000, 16'h0000, 16'd255, 1'b0);
    send_sample(1000, -1000);
    send_sample(-7, 0);
    drain();
    // zero softness leaves the integral where the clamp puts it
    configure(16'd256, 16'd1000, 16'h0000, 1'b0);
    send_sample(0, 0);
    send_sample(-32768, 32767);
    send_sample(50, 0);
    drain();
    configure(16'd384, 16'h7FFF, 16'd255, 1'b0);
    send_sample(32767, -32768);
    send_sample(-32768, 32767);
    send_sample(255, 0);
    drain();
  endtask

  // random words over a run of random register settings
  task automatic test_random_sweep;
    logic [15:0] kp, lim, soft_val;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0:       kp = 16'h0000;
        1:       kp = 16'hFFFF;
        2:       kp = 16'd256;
        default: kp = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 2))
        0:       lim = 16'h7FFF;
        1:       lim = 16'($urandom_range(0, 255));
        default: lim = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       soft_val = 16'd1;
        1:       soft_val = 16'd255;
        2:       soft_val = 16'd5;
        default: soft_val = {8'($urandom_range(0, 255)), 8'($urandom_range(1, 255))};
      endcase
      configure(kp, lim, soft_val, phase == 3);
      repeat (120) send_random();
      drain();
    end
  endtask

  // long receiver hold so the output register fills and input stalls
  task automatic test_back_pressure;
    idle_on  = 1'b0;
    hold_len = 300;
    repeat (30) send_random();
    drain();
    idle_on = 1'b1;
  endtask

  // both sides at full rate
  task automatic test_no_idle;
    configure(16'd512, 16'd12000, 16'd20, 1'b0);
    idle_on = 1'b0;
    repeat (60) send_random();
    drain();
    idle_on = 1'b1;
  endtask

  // main sequence
  initial begin
    pred_kp       = KP_RESET;
    pred_limit    = LIMIT_RESET;
    pred_soft     = SOFT_RESET;
    pred_integral = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_random_sweep();
    test_back_pressure();
    test_no_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() > 0)
      report_mismatch("words never returned", pending_results.size(), 0);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
